// ----- hdl/linked_pool_allocator_defines.svh -----
// Assertion macros shared by the linked pool allocator RTL.
`ifndef LINKED_POOL_ALLOCATOR_DEFINES_SVH
`define LINKED_POOL_ALLOCATOR_DEFINES_SVH

`ifndef ASSERT_OFF
// Implication in the same cycle, checked on clk_i outside of reset.
`define LPA_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |-> (post)) \
    else $error(msg);
// Implication in the next cycle, checked on clk_i outside of reset.
`define LPA_ASSERT_NXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (pre) |=> (post)) \
    else $error(msg);
`else
`define LPA_ASSERT_IMP(lbl, pre, post, msg)
`define LPA_ASSERT_NXT(lbl, pre, post, msg)
`endif

`endif

// ----- hdl/lpa_pkg.sv -----
// Types and constants of the linked pool allocator.
package lpa_pkg;

  // Width of a slot number in the command and result fields.
  localparam int unsigned SLOT_W      = 6;
  localparam int unsigned ENTRIES_DEF = 64;

  // Stream widths: command tdata holds slot_index, tuser holds kind.
  localparam int unsigned IN_TDATA_W  = 8;
  localparam int unsigned IN_TUSER_W  = 2;
  // Result tdata holds result_slot, used_empty, used_first, used_last.
  localparam int unsigned OUT_TDATA_W = 24;
  localparam int unsigned OUT_TUSER_W = 1;

  typedef enum logic [1:0] {
    KIND_ALLOC   = 2'd0,
    KIND_USE     = 2'd1,
    KIND_FREE    = 2'd2,
    KIND_RELEASE = 2'd3
  } lpa_kind_e;

  typedef enum logic [1:0] {
    MEMB_FREE     = 2'd0,
    MEMB_USED     = 2'd1,
    MEMB_DETACHED = 2'd2
  } lpa_memb_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_UNLINK,
    ST_RELINK,
    ST_APPEND,
    ST_TAIL
  } lpa_state_e;

endpackage

// ----- hdl/linked_pool_allocator.sv -----
// Top level of the linked pool allocator: slot pool kept on free and used lists.
//
//  channel   direction  tdata                              tuser
//  s_axis    in         slot_index                         kind
//  m_axis    out        result_slot, used_empty, first...  status
//
// Allocate, use and free step through unlink, append and tail states; a slot in the middle
// of its list adds a relink state, since two neighbor links share one memory write port.
// The result becomes valid as the allocator returns to idle, where the next command can
// transfer. Release appends nothing and skips the append state; failed or ignored commands
// go from idle straight to the tail state. After reset a clearing pass fills the links with
// no transfer taken. A result that waits on m_axis stalls only the final write of the next command.
`include "linked_pool_allocator_defines.svh"

module linked_pool_allocator #(
  parameter int unsigned ENTRIES = lpa_pkg::ENTRIES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid_i,
  output logic                            s_axis_tready_o,
  // [5:0] slot_index, [7:6] zero
  input  logic [lpa_pkg::IN_TDATA_W-1:0]  s_axis_tdata_i,
  // [1:0] kind
  input  logic [lpa_pkg::IN_TUSER_W-1:0]  s_axis_tuser_i,
  output logic                            m_axis_tvalid_o,
  input  logic                            m_axis_tready_i,
  // [5:0] result_slot, [6] used_empty, [12:7] used_first, [18:13] used_last,
  // [23:19] zero
  output logic [lpa_pkg::OUT_TDATA_W-1:0] m_axis_tdata_o,
  // [0] status
  output logic [lpa_pkg::OUT_TUSER_W-1:0] m_axis_tuser_o
);
  import lpa_pkg::*;

  localparam int unsigned AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [AW-1:0] LAST = AW'(ENTRIES - 1);

  typedef struct packed {
    lpa_memb_e     memb;
    logic [AW-1:0] prev;
    logic [AW-1:0] next;
  } slot_t;

  // Slot memory and its ports.
  slot_t         mem_q [ENTRIES];
  slot_t         rd_q;
  logic [AW-1:0] rd_addr;
  logic          wr_en, we_next, we_prev, we_memb;
  logic [AW-1:0] wr_addr, wd_next, wd_prev;
  lpa_memb_e     wd_memb;

  // Control and list registers.
  lpa_state_e    state_q, state_d;
  lpa_kind_e     kind_q, kind_d;
  logic [AW-1:0] slot_q, slot_d, clr_q, clr_d;
  logic [AW-1:0] p_q, p_d, n_q, n_d, tail_t_q, tail_t_d;
  logic          skip_q, skip_d, status_q, status_d, app_empty_q, app_empty_d;
  logic [AW-1:0] free_head_q, free_head_d, free_tail_q, free_tail_d;
  logic [AW-1:0] used_head_q, used_head_d, used_tail_q, used_tail_d;
  logic          free_empty_q, free_empty_d, used_none_q, used_none_d;

  // Result register.
  logic              out_valid_q, out_valid_d, out_status_q, out_status_d;
  logic              out_empty_q, out_empty_d;
  logic [SLOT_W-1:0] out_slot_q, out_slot_d, out_first_q, out_first_d;
  logic [SLOT_W-1:0] out_last_q, out_last_d;
  logic              out_free;

  // Helpers for the list chosen in a state.
  lpa_kind_e     in_kind;
  logic          idx_ok, in_list, sel_used, to_used;
  logic [AW-1:0] lh, lt, nh, nt;
  logic          le, ne;

  assign in_kind  = lpa_kind_e'(s_axis_tuser_i);
  assign idx_ok   = (32'(s_axis_tdata_i[SLOT_W-1:0]) < ENTRIES);
  assign out_free = !out_valid_q || m_axis_tready_i;
  assign to_used  = (kind_q != KIND_FREE);

  // Next state, memory accesses and list updates.
  always_comb begin
    state_d      = state_q;
    kind_d       = kind_q;
    slot_d       = slot_q;
    clr_d        = clr_q;
    p_d          = p_q;
    n_d          = n_q;
    tail_t_d     = tail_t_q;
    skip_d       = skip_q;
    status_d     = status_q;
    app_empty_d  = app_empty_q;
    free_head_d  = free_head_q;
    free_tail_d  = free_tail_q;
    free_empty_d = free_empty_q;
    used_head_d  = used_head_q;
    used_tail_d  = used_tail_q;
    used_none_d  = used_none_q;
    out_valid_d  = out_valid_q && !m_axis_tready_i;
    out_status_d = out_status_q;
    out_slot_d   = out_slot_q;
    out_empty_d  = out_empty_q;
    out_first_d  = out_first_q;
    out_last_d   = out_last_q;
    s_axis_tready_o = 1'b0;
    rd_addr  = slot_q;
    wr_en    = 1'b0;
    we_next  = 1'b0;
    we_prev  = 1'b0;
    we_memb  = 1'b0;
    wr_addr  = slot_q;
    wd_next  = '0;
    wd_prev  = '0;
    wd_memb  = MEMB_FREE;
    in_list  = (rd_q.memb == MEMB_FREE) || (rd_q.memb == MEMB_USED);
    sel_used = (rd_q.memb == MEMB_USED);
    lh = '0;
    lt = '0;
    le = 1'b1;
    nh = '0;
    nt = '0;
    ne = 1'b1;

    case (state_q)
      ST_CLEAR: begin
        // One entry a cycle: chain every slot into the free list.
        wr_en   = 1'b1;
        we_next = 1'b1;
        we_prev = 1'b1;
        we_memb = 1'b1;
        wr_addr = clr_q;
        wd_next = (clr_q == LAST) ? '0 : clr_q + AW'(1);
        wd_prev = (clr_q == '0) ? LAST : clr_q - AW'(1);
        wd_memb = MEMB_FREE;
        if (clr_q == LAST) begin
          state_d = ST_IDLE;
        end else begin
          clr_d = clr_q + AW'(1);
        end
      end

      ST_IDLE: begin
        // Pick the slot the command works on and start reading its links.
        s_axis_tready_o = 1'b1;
        case (in_kind)
          KIND_ALLOC: begin
            slot_d   = free_head_q;
            skip_d   = free_empty_q;
            status_d = free_empty_q;
          end
          KIND_RELEASE: begin
            slot_d   = used_tail_q;
            skip_d   = used_none_q;
            status_d = used_none_q;
          end
          default: begin
            slot_d   = AW'(s_axis_tdata_i[SLOT_W-1:0]);
            skip_d   = !idx_ok;
            status_d = 1'b0;
          end
        endcase
        rd_addr = slot_d;
        if (s_axis_tvalid_i) begin
          kind_d  = in_kind;
          state_d = skip_d ? ST_TAIL : ST_UNLINK;
        end else begin
          slot_d   = slot_q;
          skip_d   = skip_q;
          status_d = status_q;
        end
      end

      ST_UNLINK: begin
        // Take the slot out of the list that holds it.
        lh = sel_used ? used_head_q : free_head_q;
        lt = sel_used ? used_tail_q : free_tail_q;
        le = sel_used ? used_none_q : free_empty_q;
        nh = lh;
        nt = lt;
        ne = le;
        state_d = (kind_q == KIND_RELEASE) ? ST_TAIL : ST_APPEND;
        if (in_list && !le) begin
          if (lh == slot_q && lt == slot_q) begin
            ne = 1'b1;
            nh = '0;
            nt = '0;
          end else if (lh == slot_q) begin
            nh = rd_q.next;
          end else if (lt == slot_q) begin
            nt = rd_q.prev;
          end else begin
            wr_en   = 1'b1;
            we_next = 1'b1;
            wr_addr = rd_q.prev;
            wd_next = rd_q.next;
            p_d     = rd_q.prev;
            n_d     = rd_q.next;
            state_d = ST_RELINK;
          end
          if (sel_used) begin
            used_head_d = nh;
            used_tail_d = nt;
            used_none_d = ne;
          end else begin
            free_head_d  = nh;
            free_tail_d  = nt;
            free_empty_d = ne;
          end
        end
      end

      ST_RELINK: begin
        // Second half of a middle unlink: the successor points back.
        wr_en   = 1'b1;
        we_prev = 1'b1;
        wr_addr = n_q;
        wd_prev = p_q;
        state_d = (kind_q == KIND_RELEASE) ? ST_TAIL : ST_APPEND;
      end

      ST_APPEND: begin
        // Link the current tail of the target list forward to the slot.
        lt = to_used ? used_tail_q : free_tail_q;
        le = to_used ? used_none_q : free_empty_q;
        app_empty_d = le;
        tail_t_d    = lt;
        if (!le) begin
          wr_en   = 1'b1;
          we_next = 1'b1;
          wr_addr = lt;
          wd_next = slot_q;
        end
        state_d = ST_TAIL;
      end

      ST_TAIL: begin
        // Finish the slot entry and list ends, and load the result.
        if (out_free) begin
          if (!skip_q) begin
            wr_en   = 1'b1;
            we_memb = 1'b1;
            wr_addr = slot_q;
            if (kind_q == KIND_RELEASE) begin
              wd_memb = MEMB_DETACHED;
            end else begin
              wd_memb = to_used ? MEMB_USED : MEMB_FREE;
              if (!app_empty_q) begin
                we_prev = 1'b1;
                wd_prev = tail_t_q;
              end
              if (to_used) begin
                used_tail_d = slot_q;
                if (app_empty_q) begin
                  used_head_d = slot_q;
                  used_none_d = 1'b0;
                end
              end else begin
                free_tail_d = slot_q;
                if (app_empty_q) begin
                  free_head_d  = slot_q;
                  free_empty_d = 1'b0;
                end
              end
            end
          end
          out_valid_d  = 1'b1;
          out_status_d = status_q;
          out_slot_d   = (!skip_q && (kind_q == KIND_ALLOC || kind_q == KIND_RELEASE))
                         ? SLOT_W'(slot_q) : '0;
          out_empty_d  = used_none_d;
          out_first_d  = used_none_d ? '0 : SLOT_W'(used_head_d);
          out_last_d   = used_none_d ? '0 : SLOT_W'(used_tail_d);
          state_d      = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Slot memory: per-field write enables, registered read.
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      if (we_next) begin
        mem_q[wr_addr].next <= wd_next;
      end
      if (we_prev) begin
        mem_q[wr_addr].prev <= wd_prev;
      end
      if (we_memb) begin
        mem_q[wr_addr].memb <= wd_memb;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    rd_q <= mem_q[rd_addr];
  end

  // Control and list registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_CLEAR;
      clr_q        <= '0;
      free_head_q  <= '0;
      free_tail_q  <= LAST;
      free_empty_q <= 1'b0;
      used_head_q  <= '0;
      used_tail_q  <= '0;
      used_none_q  <= 1'b1;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      clr_q        <= clr_d;
      free_head_q  <= free_head_d;
      free_tail_q  <= free_tail_d;
      free_empty_q <= free_empty_d;
      used_head_q  <= used_head_d;
      used_tail_q  <= used_tail_d;
      used_none_q  <= used_none_d;
      out_valid_q  <= out_valid_d;
    end
  end

  // Command and result payload.
  always_ff @(posedge clk_i) begin
    kind_q       <= kind_d;
    slot_q       <= slot_d;
    p_q          <= p_d;
    n_q          <= n_d;
    tail_t_q     <= tail_t_d;
    skip_q       <= skip_d;
    status_q     <= status_d;
    app_empty_q  <= app_empty_d;
    out_status_q <= out_status_d;
    out_slot_q   <= out_slot_d;
    out_empty_q  <= out_empty_d;
    out_first_q  <= out_first_d;
    out_last_q   <= out_last_d;
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tuser_o  = out_status_q;
  assign m_axis_tdata_o  = {(OUT_TDATA_W - 3 * SLOT_W - 1)'(0),
                            out_last_q, out_first_q, out_empty_q, out_slot_q};

  // Checks on the sequencer and the list ends.
  `LPA_ASSERT_IMP(a_used_none_ends, used_none_q,
    (used_head_q == '0) && (used_tail_q == '0), "used list empty but ends nonzero")
  `LPA_ASSERT_NXT(a_tail_loads_result, (state_q == ST_TAIL) && out_free,
    out_valid_q && (state_q == ST_IDLE), "finished command did not load a result")
  `LPA_ASSERT_NXT(a_accept_leaves_idle, s_axis_tvalid_i && s_axis_tready_o,
    state_q != ST_IDLE, "accepted command did not start")
  `LPA_ASSERT_IMP(a_write_in_range, wr_en,
    32'(wr_addr) < ENTRIES, "slot memory write beyond the pool")

endmodule
